@@ design/tfu_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Typed field unpacker package
// Shared types and constants: parse phases, part codes, register indexes and
// the result record.
// ----------------------------------------------------------------------------
package tfu_pkg;

   localparam int NUM_BYTES = 8;   // payload bytes of a number field
   localparam int LEN_BYTES = 4;   // length bytes of a string field
   localparam int CNT_W     = 3;

   localparam logic [7:0]  NUM_TAG_RESET   = 8'd1;
   localparam logic [7:0]  STR_TAG_RESET   = 8'd2;
   localparam logic [15:0] FIELD_LIM_RESET = 16'hFFFF;

   typedef enum logic [1:0] {
      REG_NUMBER_TAG  = 2'd0,
      REG_STRING_TAG  = 2'd1,
      REG_FIELD_LIMIT = 2'd2
   } reg_index_type;

   typedef enum logic [1:0] {
      PH_TAG = 2'd0,
      PH_NUM = 2'd1,
      PH_LEN = 2'd2,
      PH_STR = 2'd3
   } phase_type;

   typedef enum logic [2:0] {
      PART_TAG = 3'd0,
      PART_NUM = 3'd1,
      PART_LEN = 3'd2,
      PART_STR = 3'd3,
      PART_IGN = 3'd4
   } part_type;

   typedef struct packed {
      logic [7:0]  number_tag;
      logic [7:0]  string_tag;
      logic [15:0] field_limit;
   } cfg_type;

   typedef struct packed {
      logic [15:0] field_index;
      logic [7:0]  field_tag;
      part_type    part;
      logic [7:0]  byte_value;
      logic        field_end;
      logic        status;
      logic        buffer_end;
   } result_type;

endpackage

@@ design/tfu_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Typed field unpacker channel interfaces
// Valid/ready channels for input bytes, results and register writes.
// ----------------------------------------------------------------------------
interface tfu_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface tfu_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] field_index;
   logic [7:0]  field_tag;
   logic [2:0]  part;
   logic [7:0]  byte_value;
   logic        field_end;
   logic        status;
   logic        buffer_end;

   modport source (output valid, output field_index, output field_tag, output part,
                   output byte_value, output field_end, output status,
                   output buffer_end, input ready);
   modport sink   (input valid, input field_index, input field_tag, input part,
                   input byte_value, input field_end, input status,
                   input buffer_end, output ready);
endinterface

interface tfu_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  reg_index;
   logic [15:0] wdata;

   modport source (output valid, output reg_index, output wdata, input ready);
   modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

@@ design/typed_field_unpacker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Typed field unpacker
// Streaming tag-length-value parser: classifies each buffer byte as tag,
// number byte, length byte, string byte or ignored.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                        handshake
//  req_if   in   data_byte, last_byte                           valid/ready
//  rsp_if   out  field_index, field_tag, part, byte_value,      valid/ready
//                field_end, status, buffer_end
//  csr_if   in   reg_index, wdata                               valid/ready
//
//  One result per byte, registered in the cycle after its transfer; one byte
//  per cycle with no rsp_if stall, set by the single result register after parse.
//  req_if.ready drops only while a held result is stalled by rsp_if.ready.
//  Synchronous reset restores the register defaults and the start state.
//  Register writes are always accepted; csr_if.ready is tied high.
// ----------------------------------------------------------------------------
module typed_field_unpacker (
   input logic      clock,
   input logic      reset,
   tfu_req_if.sink  req_if,
   tfu_rsp_if.source rsp_if,
   tfu_csr_if.sink  csr_if
);
   import tfu_pkg::*;

   cfg_type    cfg;
   result_type parse_result;
   result_type held_result;
   logic       req_ready;
   logic       accept;

   assign req_if.ready = req_ready;
   assign accept       = req_if.valid && req_ready;

   tfu_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (csr_if.valid),
      .wr_ready (csr_if.ready),
      .wr_index (csr_if.reg_index),
      .wr_data  (csr_if.wdata),
      .cfg      (cfg)
   );

   tfu_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .data_byte (req_if.data_byte),
      .last_byte (req_if.last_byte),
      .cfg       (cfg),
      .result    (parse_result)
   );

   tfu_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_if.valid),
      .in_ready  (req_ready),
      .in_data   (parse_result),
      .out_valid (rsp_if.valid),
      .out_ready (rsp_if.ready),
      .out_data  (held_result)
   );

   assign rsp_if.field_index = held_result.field_index;
   assign rsp_if.field_tag   = held_result.field_tag;
   assign rsp_if.part        = 3'(held_result.part);
   assign rsp_if.byte_value  = held_result.byte_value;
   assign rsp_if.field_end   = held_result.field_end;
   assign rsp_if.status      = held_result.status;
   assign rsp_if.buffer_end  = held_result.buffer_end;

endmodule

@@ design/tfu_csr.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Typed field unpacker registers
// Holds the number tag, string tag and field limit; writes always complete.
// ----------------------------------------------------------------------------
module tfu_csr (
   input  logic           clock,
   input  logic           reset,
   input  logic           wr_valid,
   output logic           wr_ready,
   input  logic [1:0]     wr_index,
   input  logic [15:0]    wr_data,
   output tfu_pkg::cfg_type cfg
);
   import tfu_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign wr_ready = 1'b1;
   assign cfg      = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_valid) begin
         case (reg_index_type'(wr_index))
            REG_NUMBER_TAG:  cfg_in.number_tag  = wr_data[7:0];
            REG_STRING_TAG:  cfg_in.string_tag  = wr_data[7:0];
            REG_FIELD_LIMIT: cfg_in.field_limit = wr_data;
            default:         cfg_in = cfg_ff;   // unmapped index
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.number_tag  <= NUM_TAG_RESET;
         cfg_ff.string_tag  <= STR_TAG_RESET;
         cfg_ff.field_limit <= FIELD_LIM_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ design/tfu_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Typed field unpacker parse core
// Holds the parse state and classifies one byte per transfer.
// ----------------------------------------------------------------------------
module tfu_parser (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [7:0]          data_byte,
   input  logic                last_byte,
   input  tfu_pkg::cfg_type    cfg,
   output tfu_pkg::result_type result
);
   import tfu_pkg::*;

   localparam logic [CNT_W-1:0] NumLastCnt = CNT_W'(NUM_BYTES - 1);
   localparam logic [CNT_W-1:0] LenLastCnt = CNT_W'(LEN_BYTES - 1);

   phase_type        phase_ff,  phase_in;
   logic [CNT_W-1:0] cnt_ff,    cnt_in;
   logic [31:0]      accum_ff,  accum_in;
   logic [31:0]      remain_ff, remain_in;
   logic [15:0]      done_ff,   done_in;
   logic [7:0]       tag_ff,    tag_in;

   logic [31:0] accum_new;
   logic [31:0] remain_dec;
   logic        finish;

   assign accum_new  = accum_ff | (32'(data_byte) << {cnt_ff[1:0], 3'b000});
   assign remain_dec = remain_ff - 32'(remain_ff != 32'd0);

   always_comb begin
      phase_in  = phase_ff;
      cnt_in    = cnt_ff;
      accum_in  = accum_ff;
      remain_in = remain_ff;
      done_in   = done_ff;
      tag_in    = tag_ff;
      finish    = 1'b0;

      result.field_index = done_ff;
      result.field_tag   = tag_ff;
      result.part        = PART_TAG;
      result.byte_value  = data_byte;
      result.field_end   = 1'b0;
      result.status      = 1'b0;
      result.buffer_end  = last_byte;

      case (phase_ff)
         PH_NUM: begin
            result.part = PART_NUM;
            if (cnt_ff == NumLastCnt) begin
               finish = 1'b1;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         PH_LEN: begin
            result.part = PART_LEN;
            if (cnt_ff == LenLastCnt) begin
               cnt_in   = '0;
               accum_in = '0;
               if (accum_new == 32'd0) begin
                  finish = 1'b1;      // empty string ends on its length
               end else begin
                  remain_in = accum_new;
                  phase_in  = PH_STR;
               end
            end else begin
               accum_in = accum_new;
               cnt_in   = cnt_ff + 1'b1;
            end
         end
         PH_STR: begin
            result.part = PART_STR;
            remain_in   = remain_dec;
            if (remain_dec == 32'd0) begin
               finish = 1'b1;
            end
         end
         default: begin
            if (done_ff >= cfg.field_limit) begin
               // limit reached: byte ignored, state held
               result.part        = PART_IGN;
               result.field_index = '0;
               result.field_tag   = '0;
            end else begin
               result.field_tag = data_byte;
               tag_in           = data_byte;
               cnt_in           = '0;
               accum_in         = '0;
               if (data_byte == cfg.number_tag) begin
                  phase_in = PH_NUM;
               end else if (data_byte == cfg.string_tag) begin
                  phase_in = PH_LEN;
               end else begin
                  finish = 1'b1;
               end
            end
         end
      endcase

      if (finish) begin
         result.field_end = 1'b1;
         done_in          = done_ff + 16'd1;
         phase_in         = PH_TAG;
         cnt_in           = '0;
      end

      if (last_byte) begin
         result.status = (phase_in != PH_TAG);
         phase_in  = PH_TAG;
         cnt_in    = '0;
         accum_in  = '0;
         remain_in = '0;
         done_in   = '0;
         tag_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_TAG;
         cnt_ff    <= '0;
         accum_ff  <= '0;
         remain_ff <= '0;
         done_ff   <= '0;
         tag_ff    <= '0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         cnt_ff    <= cnt_in;
         accum_ff  <= accum_in;
         remain_ff <= remain_in;
         done_ff   <= done_in;
         tag_ff    <= tag_in;
      end
   end

   // Buffer end returns the parser to its start state.
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      accept && last_byte |=> phase_ff == PH_TAG && done_ff == 16'd0 && cnt_ff == '0)
      else $error("parse state not cleared after final byte");

   a_status_only_last: assert property (@(posedge clock) disable iff (reset)
      accept && result.status |-> last_byte)
      else $error("truncation flagged on a non-final byte");

   a_ignored_shape: assert property (@(posedge clock) disable iff (reset)
      accept && result.part == PART_IGN |->
         !result.field_end && result.field_index == 16'd0 && result.field_tag == 8'd0)
      else $error("ignored byte carries field data");

   a_string_nonzero: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_STR |-> remain_ff != 32'd0)
      else $error("string phase with nothing remaining");

endmodule

@@ design/tfu_out_reg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Typed field unpacker result register
// One-entry output stage; refills in the cycle the held result transfers.
// ----------------------------------------------------------------------------
module tfu_out_reg (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  tfu_pkg::result_type in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output tfu_pkg::result_type out_data
);
   import tfu_pkg::*;

   logic       valid_ff, valid_in;
   result_type data_ff;

   assign in_ready  = !valid_ff || out_ready;
   assign valid_in  = (in_valid && in_ready) || (valid_ff && !out_ready);
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_valid && in_ready) begin
         data_ff <= in_data;
      end
   end

endmodule

@@ tb/sv/tfu_stream_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Typed field unpacker stream checker
// Watches the byte, result and register channels, keeps its own copy of the
// parse state and registers, predicts one result per byte transfer and
// compares each result transfer field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tfu_stream_checker (
   input  logic        clock,
   input  logic        reset,
   tfu_req_if          req_mon,
   tfu_rsp_if          rsp_mon,
   tfu_csr_if          csr_mon,
   input  logic        run_done,
   output int unsigned fail_count,
   output int unsigned results_outstanding
);
   import tfu_pkg::*;

   // register copy
   logic [7:0]  cfg_number_tag;
   logic [7:0]  cfg_string_tag;
   logic [15:0] cfg_field_limit;

   // parse state copy
   phase_type   st_phase;
   int unsigned st_count;
   logic [31:0] st_length;
   logic [31:0] st_remaining;
   logic [15:0] st_fields;
   logic [7:0]  st_tag;

   result_type  pending_results[$];
   int unsigned mismatches;
   int unsigned results_checked;
   int unsigned part_count[5];
   int unsigned buffers_seen;
   int unsigned truncated_seen;
   int unsigned reg_writes;
   bit          end_reported;

   function automatic void clear_parse_state();
      st_phase     = PH_TAG;
      st_count     = 0;
      st_length    = '0;
      st_remaining = '0;
      st_fields    = '0;
      st_tag       = '0;
   endfunction

   function automatic void close_field();
      st_fields = st_fields + 16'd1;
      st_phase  = PH_TAG;
      st_count  = 0;
   endfunction

   function automatic result_type decode_byte(input logic [7:0] b, input logic last);
      result_type r;
      r.field_index = st_fields;
      r.field_tag   = st_tag;
      r.part        = PART_TAG;
      r.byte_value  = b;
      r.field_end   = 1'b0;
      r.status      = 1'b0;
      r.buffer_end  = last;
      case (st_phase)
         PH_NUM: begin
            r.part = PART_NUM;
            st_count++;
            if (st_count >= NUM_BYTES) begin
               r.field_end = 1'b1;
               close_field();
            end
         end
         PH_LEN: begin
            r.part = PART_LEN;
            st_length |= 32'(b) << (8 * (st_count % LEN_BYTES));
            st_count++;
            if (st_count >= LEN_BYTES) begin
               st_count = 0;
               if (st_length == '0) begin
                  r.field_end = 1'b1;
                  close_field();
               end else begin
                  st_remaining = st_length;
                  st_phase     = PH_STR;
               end
               st_length = '0;
            end
         end
         PH_STR: begin
            r.part = PART_STR;
            if (st_remaining != '0) st_remaining--;
            if (st_remaining == '0) begin
               r.field_end = 1'b1;
               close_field();
            end
         end
         default: begin
            if (st_fields >= cfg_field_limit) begin
               // over the field limit: byte dropped, state untouched
               r.part        = PART_IGN;
               r.field_index = '0;
               r.field_tag   = '0;
            end else begin
               st_tag      = b;
               r.field_tag = b;
               st_count    = 0;
               st_length   = '0;
               // number reading takes priority when both tags match
               if (b == cfg_number_tag) begin
                  st_phase = PH_NUM;
               end else if (b == cfg_string_tag) begin
                  st_phase = PH_LEN;
               end else begin
                  r.field_end = 1'b1;
                  close_field();
               end
            end
         end
      endcase
      if (last) begin
         r.status = (st_phase != PH_TAG);
         clear_parse_state();
      end
      return r;
   endfunction

   task automatic flag_mismatch(input string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      mismatches++;
   endtask

   task automatic compare_field(input string name, input logic [15:0] got,
                                input logic [15:0] want);
      if (got !== want)
         flag_mismatch($sformatf("result %0d: %s is 0x%0h, predicted 0x%0h",
                                 results_checked, name, got, want));
   endtask

   always @(posedge clock) begin
      result_type want;
      result_type predicted;
      if (reset) begin
         cfg_number_tag  = NUM_TAG_RESET;
         cfg_string_tag  = STR_TAG_RESET;
         cfg_field_limit = FIELD_LIM_RESET;
         clear_parse_state();
         pending_results.delete();
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            reg_writes++;
            case (reg_index_type'(csr_mon.reg_index))
               REG_NUMBER_TAG:  cfg_number_tag  = csr_mon.wdata[7:0];
               REG_STRING_TAG:  cfg_string_tag  = csr_mon.wdata[7:0];
               REG_FIELD_LIMIT: cfg_field_limit = csr_mon.wdata;
               default: ;
            endcase
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (pending_results.size() == 0) begin
               flag_mismatch("result transfer with no byte outstanding");
            end else begin
               want = pending_results.pop_front();
               compare_field("field_index", rsp_mon.field_index, want.field_index);
               compare_field("field_tag", 16'(rsp_mon.field_tag), 16'(want.field_tag));
               compare_field("part", 16'(rsp_mon.part), 16'(want.part));
               compare_field("byte_value", 16'(rsp_mon.byte_value), 16'(want.byte_value));
               compare_field("field_end", 16'(rsp_mon.field_end), 16'(want.field_end));
               compare_field("status", 16'(rsp_mon.status), 16'(want.status));
               compare_field("buffer_end", 16'(rsp_mon.buffer_end), 16'(want.buffer_end));
            end
            results_checked++;
         end
         if (req_mon.valid && req_mon.ready) begin
            predicted = decode_byte(req_mon.data_byte, req_mon.last_byte);
            part_count[int'(predicted.part)]++;
            if (predicted.buffer_end) buffers_seen++;
            if (predicted.status) truncated_seen++;
            pending_results.push_back(predicted);
         end
         if (run_done && !end_reported) begin
            end_reported = 1'b1;
            if (pending_results.size() != 0)
               flag_mismatch($sformatf("%0d predicted results never arrived",
                                       pending_results.size()));
            $display({"Covered %0d bytes in %0d buffers: tag %0d, number %0d, ",
                      "length %0d, string %0d, ignored %0d"},
                     results_checked, buffers_seen, part_count[0], part_count[1],
                     part_count[2], part_count[3], part_count[4]);
            $display("%0d truncated buffers, %0d register writes, %0d mismatches",
                     truncated_seen, reg_writes, mismatches);
         end
      end
      results_outstanding <= pending_results.size();
      fail_count          <= mismatches;
   end

endmodule

@@ tb/sv/tb_typed_field_unpacker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Typed field unpacker testbench
// Drives directed and random byte buffers through the parser under several
// register settings and idle/stall mixes; the stream checker predicts and
// compares every result, this top gives the verdict.
// ----------------------------------------------------------------------------
module tb_typed_field_unpacker;
   import tfu_pkg::*;

   localparam int STALL_LIMIT = 4000;

   logic        clock;
   logic        reset;
   logic        run_done;
   int unsigned fail_count;
   int unsigned results_outstanding;

   int          send_idle_pct;
   int          stall_pct;
   int unsigned quiet_cycles;

   logic [7:0]  cfg_num;
   logic [7:0]  cfg_str;
   logic [7:0]  buffer_bytes[$];

   tfu_req_if req_if ();
   tfu_rsp_if rsp_if ();
   tfu_csr_if csr_if ();

   typed_field_unpacker u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   tfu_stream_checker u_checker (
      .clock               (clock),
      .reset               (reset),
      .req_mon             (req_if),
      .rsp_mon             (rsp_if),
      .csr_mon             (csr_if),
      .run_done            (run_done),
      .fail_count          (fail_count),
      .results_outstanding (results_outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // result side back-pressure
   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_if.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_if.valid && csr_if.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
         $display("** typed_field_unpacker: FAILED **");
         $finish;
      end
   end

   task automatic push_byte(input logic [7:0] b, input logic last);
      if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_if.valid     <= 1'b0;
         req_if.data_byte <= 8'($urandom);
         req_if.last_byte <= 1'($urandom);
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_if.valid     <= 1'b1;
      req_if.data_byte <= b;
      req_if.last_byte <= last;
      do @(posedge clock); while (!req_if.ready);
   endtask

   task automatic send_buffer();
      foreach (buffer_bytes[i]) push_byte(buffer_bytes[i], i == buffer_bytes.size() - 1);
   endtask

   // hold off the sender until every byte has its result
   task automatic wait_drained();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (results_outstanding != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_reg(input reg_index_type idx, input logic [15:0] value);
      csr_if.valid     <= 1'b1;
      csr_if.reg_index <= idx;
      csr_if.wdata     <= value;
      do @(posedge clock); while (!csr_if.ready);
   endtask

   task automatic set_config(input logic [7:0] num, input logic [7:0] str,
                             input logic [15:0] lim);
      wait_drained();
      write_reg(REG_NUMBER_TAG, {8'h00, num});
      write_reg(REG_STRING_TAG, {8'h00, str});
      write_reg(REG_FIELD_LIMIT, lim);
      csr_if.valid <= 1'b0;
      cfg_num = num;
      cfg_str = str;
   endtask

   task automatic run_phase(input int target, input int idle_pct, input int stall);
      int          sent;
      int          n_fields;
      int          mode;
      int          kind;
      int          cut;
      logic [31:0] len;
      logic [7:0]  t;
      bit          open_string;
      send_idle_pct = idle_pct;
      stall_pct     = stall;
      sent          = 0;
      while (sent < target) begin
         buffer_bytes.delete();
         open_string = 1'b0;
         mode        = $urandom_range(0, 99);
         n_fields    = $urandom_range(1, 6);
         if (mode < 8) begin
            repeat ($urandom_range(1, 12)) buffer_bytes.push_back(8'($urandom));
         end else begin
            for (int f = 0; f < n_fields && !open_string; f++) begin
               kind = $urandom_range(0, 2);
               if (kind == 0) begin
                  buffer_bytes.push_back(cfg_num);
                  repeat (NUM_BYTES) buffer_bytes.push_back(8'($urandom));
               end else if (kind == 1) begin
                  case ($urandom_range(0, 9))
                     0:       len = $urandom;
                     1, 2:    len = $urandom_range(7, 24);
                     default: len = $urandom_range(0, 6);
                  endcase
                  // a huge length cannot finish: stream a few bytes and end there
                  open_string = (len > 24);
                  buffer_bytes.push_back(cfg_str);
                  for (int k = 0; k < LEN_BYTES; k++) buffer_bytes.push_back(len[8*k +: 8]);
                  repeat (open_string ? $urandom_range(0, 5) : len)
                     buffer_bytes.push_back(8'($urandom));
               end else begin
                  do t = 8'($urandom); while (t == cfg_num || t == cfg_str);
                  buffer_bytes.push_back(t);
               end
            end
            if (mode < 25 && buffer_bytes.size() > 1) begin
               cut          = $urandom_range(1, buffer_bytes.size() - 1);
               buffer_bytes = buffer_bytes[0:cut-1];
            end
         end
         send_buffer();
         sent += buffer_bytes.size();
         if ($urandom_range(0, 11) == 0) wait_drained();
      end
   endtask

   initial begin
      logic [7:0] ta;
      logic [7:0] tb;
      reset            <= 1'b1;
      run_done         <= 1'b0;
      req_if.valid     <= 1'b0;
      req_if.data_byte <= '0;
      req_if.last_byte <= 1'b0;
      csr_if.valid     <= 1'b0;
      csr_if.reg_index <= REG_NUMBER_TAG;
      csr_if.wdata     <= '0;
      send_idle_pct    = 0;
      stall_pct        = 0;
      cfg_num          = NUM_TAG_RESET;
      cfg_str          = STR_TAG_RESET;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset register values: number field with extreme bytes, empty string,
      // short string, a payload-free tag on the final byte
      buffer_bytes = '{8'h01, 8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01, 8'hFE, 8'h55, 8'hAA,
                       8'h02, 8'h00, 8'h00, 8'h00, 8'h00,
                       8'h02, 8'h02, 8'h00, 8'h00, 8'h00, 8'h41, 8'h42,
                       8'hFF};
      send_buffer();
      // number tag as the final byte, then a buffer cut inside the length
      buffer_bytes = '{8'h01};
      send_buffer();
      buffer_bytes = '{8'h02, 8'h05};
      send_buffer();

      set_config(8'h01, 8'h02, 16'hFFFF);
      run_phase(120, 0, 0);
      set_config(8'h00, 8'hFF, 16'd3);
      run_phase(110, 81, 0);
      ta = 8'($urandom);
      set_config(ta, ta, 16'hFFFF);
      run_phase(110, 0, 81);
      set_config(8'hFF, 8'h00, 16'd0);
      run_phase(60, 29, 29);
      ta = 8'($urandom);
      tb = 8'($urandom);
      set_config(ta, tb, 16'd1);
      run_phase(110, 0, 0);
      ta = 8'($urandom);
      tb = 8'($urandom);
      set_config(ta, tb, 16'($urandom_range(2, 8)));
      run_phase(140, 29, 29);

      wait_drained();
      run_done <= 1'b1;
      repeat (3) @(posedge clock);
      if (fail_count == 0) begin
         $display("** typed_field_unpacker: PASSED **");
      end else begin
         $display("** typed_field_unpacker: FAILED **");
      end
      $finish;
   end

endmodule
